/* sv/mrp_pkg.sv */
// Shared types and constants for the MIPS ELF relocation patcher.
// No dependencies; used by mrp_alu and the top level.

package mrp_pkg;

   localparam int WORD_W     = 32;
   localparam int TYPE_W     = 8;
   localparam int REQ_DATA_W = 4 * WORD_W;
   localparam int REQ_USER_W = TYPE_W + 1;
   localparam int RSP_DATA_W = 2 * WORD_W;
   localparam int RSP_USER_W = 1;

   localparam logic [TYPE_W-1:0] TYPE_WORD32 = 8'd2;
   localparam logic [TYPE_W-1:0] TYPE_JUMP26 = 8'd4;
   localparam logic [TYPE_W-1:0] TYPE_HI16   = 8'd5;
   localparam logic [TYPE_W-1:0] TYPE_LO16   = 8'd6;

   localparam logic [WORD_W-1:0] JUMP_KEEP_MASK  = 32'hFC00_0000;
   localparam logic [WORD_W-1:0] JUMP_FIELD_MASK = 32'h03FF_FFFF;
   localparam logic [WORD_W-1:0] HI_KEEP_MASK    = 32'hFFFF_0000;
   localparam logic [WORD_W-1:0] LO_MASK         = 32'h0000_FFFF;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   localparam logic CMD_APPLY   = 1'b0;
   localparam logic CMD_SECTION = 1'b1;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_VALUE = 5'b00010,
      S_EXEC  = 5'b00100,
      S_WALK  = 5'b01000,
      S_LAST  = 5'b10000
   } state_type;

endpackage

/* sv/mrp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the pending HI16 queue.

module mrp_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mrp_alu.sv */
// Shared 32-bit adder/subtractor used by the value, execute and queue-walk steps of the sequencer.
// Depends on mrp_pkg for the word width and the operation codes.

module mrp_alu (
   input  mrp_pkg::alu_op_type              op,
   input  logic [mrp_pkg::WORD_W-1:0]       a,
   input  logic [mrp_pkg::WORD_W-1:0]       b,
   output logic [mrp_pkg::WORD_W-1:0]       sum
);

   import mrp_pkg::*;

   logic [WORD_W-1:0] b_op;
   logic              carry_in;

   always_comb begin
      unique case (op)
         ALU_ADD: begin
            b_op     = b;
            carry_in = 1'b0;
         end
         ALU_SUB: begin
            b_op     = ~b;
            carry_in = 1'b1;
         end
         default: begin
            b_op     = b;
            carry_in = 1'b0;
         end
      endcase
   end

   assign sum = a + b_op + {{(WORD_W-1){1'b0}}, carry_in};

endmodule

/* sv/mips_elf_relocation_patcher.sv */
// MIPS ELF32 relocation patcher: WORD32, JUMP26, HI16/LO16 pairing with a HI16 queue.
// Depends on mrp_pkg, mrp_alu and mrp_ram.
//
//  channel | direction | tdata (low bit up)                           | tuser / tlast
//  req     | in        | location, target_word, symbol_address, addend | tuser: command, reloc_type
//  rsp     | out       | patch_location, patch_word                    | tuser: status; tlast: last
//
// An item is taken only in the idle state; req_tready drops until its work is done.
// WORD32, JUMP26, error and HI16 items pass through the value and execute states; new-section is handled in idle.
// LO16 adds a queue walk over the queued HI16 entries, one entry per cycle unless a held result stalls it.
// Each result held in the output register stalls the sequencer until it is taken.
// Reset empties the queue count; queue storage needs no clearing.

module mips_elf_relocation_patcher #(
   parameter int QUEUE_DEPTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // location, target_word, symbol_address, addend
   input  logic [mrp_pkg::REQ_DATA_W-1:0]    req_tdata,
   // command, reloc_type
   input  logic [mrp_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // patch_location, patch_word
   output logic [mrp_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // status
   output logic [mrp_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                              rsp_tlast
);

   import mrp_pkg::*;

   localparam int IDX_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int ENTRY_W = 3 * WORD_W;

   state_type          state_ff, state_in;
   logic [TYPE_W-1:0]  type_ff, type_in;
   logic [WORD_W-1:0]  loc_ff, loc_in;
   logic [WORD_W-1:0]  word_ff, word_in;
   logic [WORD_W-1:0]  sym_ff, sym_in;
   logic [WORD_W-1:0]  add_ff, add_in;
   logic [WORD_W-1:0]  value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   keep_ff, keep_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_loc_ff, rsp_loc_in;
   logic [WORD_W-1:0]  rsp_word_ff, rsp_word_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   logic [WORD_W-1:0]  rd_loc, rd_word, rd_value;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   alu_op_type         alu_op;
   logic [WORD_W-1:0]  alu_a, alu_b, alu_sum;

   logic [WORD_W-1:0]  lo_ext;
   logic               hit;
   logic               out_free;
   logic               rsp_load;
   logic               walk_last;
   logic               req_accept;

   mrp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mrp_alu u_alu (
      .op  (alu_op),
      .a   (alu_a),
      .b   (alu_b),
      .sum (alu_sum)
   );

   assign rd_loc   = rd_data[WORD_W-1:0];
   assign rd_word  = rd_data[2*WORD_W-1:WORD_W];
   assign rd_value = rd_data[3*WORD_W-1:2*WORD_W];

   assign lo_ext    = {{(WORD_W/2){value_ff[WORD_W/2-1]}}, value_ff[WORD_W/2-1:0]};
   assign hit       = (rd_value == value_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign walk_last = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      loc_in        = loc_ff;
      word_in       = word_ff;
      sym_in        = sym_ff;
      add_in        = add_ff;
      value_in      = value_ff;
      count_in      = count_ff;
      keep_in       = keep_ff;
      idx_in        = idx_ff;
      rsp_load      = 1'b0;
      rsp_loc_in    = rsp_loc_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = count_ff[IDX_W-1:0];
      wr_data       = {value_ff, word_ff, loc_ff};
      alu_op        = ALU_ADD;
      alu_a         = sym_ff;
      alu_b         = add_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               type_in = req_tuser[TYPE_W:1];
               loc_in  = req_tdata[WORD_W-1:0];
               word_in = req_tdata[2*WORD_W-1:WORD_W];
               sym_in  = req_tdata[3*WORD_W-1:2*WORD_W];
               add_in  = req_tdata[4*WORD_W-1:3*WORD_W];
               if (req_tuser[0] == CMD_SECTION) begin
                  count_in = '0;
               end else begin
                  state_in = S_VALUE;
               end
            end
         end
         S_VALUE: begin
            value_in = alu_sum;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            alu_a = word_ff;
            alu_b = value_ff;
            case (type_ff)
               TYPE_WORD32: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_loc_in    = loc_ff;
                     rsp_word_in   = alu_sum;
                     rsp_status_in = STATUS_OK;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               TYPE_JUMP26: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_loc_in    = loc_ff;
                     rsp_word_in   = (word_ff & JUMP_KEEP_MASK) |
                                     ({2'b00, value_ff[WORD_W-1:2]} & JUMP_FIELD_MASK);
                     rsp_status_in = STATUS_OK;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
               TYPE_HI16: begin
                  // drop the entry when the queue is full
                  if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + CNT_W'(1);
                  end
                  state_in = S_IDLE;
               end
               TYPE_LO16: begin
                  idx_in  = '0;
                  keep_in = '0;
                  rd_addr = '0;
                  if (count_ff == '0) begin
                     state_in = S_LAST;
                  end else begin
                     state_in = S_WALK;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_load      = 1'b1;
                     rsp_loc_in    = loc_ff;
                     rsp_word_in   = word_ff;
                     rsp_status_in = STATUS_ERROR;
                     rsp_last_in   = 1'b1;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end
         S_WALK: begin
            alu_op = ALU_SUB;
            alu_a  = rd_value;
            alu_b  = lo_ext;
            if (hit && !out_free) begin
               // hold the entry on the read port until the result slot frees
               rd_addr = idx_ff;
            end else begin
               if (hit) begin
                  rsp_load      = 1'b1;
                  rsp_loc_in    = rd_loc;
                  rsp_word_in   = (rd_word & HI_KEEP_MASK) |
                                  {{(WORD_W/2){1'b0}}, alu_sum[WORD_W-1:WORD_W/2]};
                  rsp_status_in = STATUS_OK;
                  rsp_last_in   = 1'b0;
               end else begin
                  // compact: move the kept entry down to the keep slot
                  wr_en   = 1'b1;
                  wr_addr = keep_ff[IDX_W-1:0];
                  wr_data = rd_data;
                  keep_in = keep_ff + CNT_W'(1);
               end
               if (walk_last) begin
                  count_in = keep_in;
                  state_in = S_LAST;
               end else begin
                  idx_in  = idx_ff + IDX_W'(1);
                  rd_addr = idx_in;
               end
            end
         end
         S_LAST: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_loc_in    = loc_ff;
               rsp_word_in   = (word_ff & HI_KEEP_MASK) | (value_ff & LO_MASK);
               rsp_status_in = STATUS_OK;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      loc_ff        <= loc_in;
      word_ff       <= word_in;
      sym_ff        <= sym_in;
      add_ff        <= add_in;
      value_ff      <= value_in;
      keep_ff       <= keep_in;
      idx_ff        <= idx_in;
      rsp_loc_ff    <= rsp_loc_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_word_ff, rsp_loc_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (keep_ff <= CNT_W'(idx_ff)))
      else $error("compaction slot ahead of walk index");

   a_walk_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (count_ff != '0))
      else $error("queue walk on an empty queue");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> out_free)
      else $error("result register overwritten before transfer");

   a_section_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_tuser[0] == CMD_SECTION)) |=> (count_ff == '0))
      else $error("new section did not empty the queue");

endmodule
